>>> rtl/core/double_ended_queue_defines.svh
// Assertion macros for the checker file of the deque.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Check a property on every rising edge, skipped while reset is asserted.
`define DEQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define DEQ_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/deq_pkg.sv
package deq_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int CMD_W   = 3;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = $clog2(DEPTH);

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

	// Result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// Operation applied to the whole row of cells together
	typedef enum logic [2:0] {
		OP_HOLD    = 3'd0,
		OP_SHIFT_R = 3'd1,
		OP_SHIFT_L = 3'd2,
		OP_WRITE   = 3'd3,
		OP_ROTATE  = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 op;
		logic signed [DATA_W-1:0] ins;
	} cell_ctl_t;

endpackage

>>> rtl/core/deq_cmd_if.sv
interface deq_cmd_if;
	import deq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, cmd, value, input ready);
	modport sink (input valid, cmd, value, output ready);
endinterface

>>> rtl/core/deq_res_if.sv
interface deq_res_if;
	import deq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] element;
	logic                     last;

	modport source (output valid, status, element, last, input ready);
	modport sink (input valid, status, element, last, output ready);
endinterface

>>> rtl/core/deq_cell.sv
module deq_cell (
	input  logic                              clk,
	input  deq_pkg::cell_ctl_t                ctl,
	input  logic                              hit,
	input  logic signed [deq_pkg::DATA_W-1:0] left,
	input  logic signed [deq_pkg::DATA_W-1:0] right,
	output logic signed [deq_pkg::DATA_W-1:0] data
);
	import deq_pkg::*;

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;

	// Pick the next value from a neighbor, the broadcast word, or hold
	always_comb begin
		data_d = data_q;
		case (ctl.op)
			OP_HOLD:    data_d = data_q;
			OP_SHIFT_R: data_d = left;
			OP_SHIFT_L: data_d = right;
			OP_WRITE:   data_d = hit ? ctl.ins : data_q;
			OP_ROTATE:  data_d = hit ? ctl.ins : right;
			default:    data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;
endmodule

>>> rtl/core/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values, DEPTH entries.
// Channels: req carries a command (push front, push back, pop front,
// pop back, dump) and a value; rsp returns results with status,
// element and a last mark. Both use valid/ready; a transfer happens on
// a rising edge with valid and ready high.
// Storage is a row of cells, cell 0 holding the front element. A push
// at the front shifts the row right, a pop at the front shifts it left,
// a push at the back writes the cell at the occupancy count.
// Push and pop: one result, registered, in the cycle after the transfer;
// a new command is taken every cycle while rsp keeps up.
// Dump: one result per stored element, or one empty result if none;
// one per cycle while rsp keeps up, given from the dump state, read
// from cell 0 while the occupied part of the row rotates by one; req is
// not ready until the last is loaded. Codes five to seven are taken and
// produce no result. Reset empties the queue and drops any pending
// result; cell contents are not cleared. When rsp stalls, the result
// register holds and req stays not ready until the result is taken.
module double_ended_queue (
	input  logic      clk,
	input  logic      arst_n,
	deq_cmd_if.sink   req,
	deq_res_if.source rsp
);
	import deq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [IDX_W-1:0]         dump_idx_q, dump_idx_d;
	logic                     rsp_valid_q, rsp_valid_d;
	logic [1:0]               rsp_status_q;
	logic signed [DATA_W-1:0] rsp_element_q;
	logic                     rsp_last_q;

	cell_ctl_t                ctl;
	logic [CNT_W-1:0]         target;
	logic [DEPTH-1:0]         hit;
	logic signed [DATA_W-1:0] cell_data [DEPTH];

	logic                     out_free;
	logic                     accept;
	logic                     full;
	logic                     empty;
	logic                     load;
	logic [1:0]               load_status;
	logic signed [DATA_W-1:0] load_element;
	logic                     load_last;
	logic                     dump_last;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign dump_last = ((CNT_W'(dump_idx_q) + CNT_W'(1)) == count_q);

	// Decode the command or advance the dump
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		dump_idx_d   = dump_idx_q;
		ctl.op       = OP_HOLD;
		ctl.ins      = req.value;
		target       = count_q;
		load         = 1'b0;
		load_status  = STAT_OK;
		load_element = '0;
		load_last    = 1'b1;

		if (accept) begin
			case (req.cmd)
				CMD_PUSH_FRONT: begin
					load = 1'b1;
					if (full) begin
						load_status = STAT_FULL;
					end else begin
						ctl.op  = OP_SHIFT_R;
						count_d = count_q + CNT_W'(1);
					end
				end
				CMD_PUSH_BACK: begin
					load = 1'b1;
					if (full) begin
						load_status = STAT_FULL;
					end else begin
						ctl.op  = OP_WRITE;
						count_d = count_q + CNT_W'(1);
					end
				end
				CMD_POP_FRONT: begin
					load = 1'b1;
					if (empty) begin
						load_status = STAT_EMPTY;
					end else begin
						ctl.op  = OP_SHIFT_L;
						count_d = count_q - CNT_W'(1);
					end
				end
				CMD_POP_BACK: begin
					load = 1'b1;
					if (empty) begin
						load_status = STAT_EMPTY;
					end else begin
						count_d = count_q - CNT_W'(1);
					end
				end
				CMD_DUMP: begin
					if (empty) begin
						load        = 1'b1;
						load_status = STAT_EMPTY;
					end else begin
						state_d    = S_DUMP;
						dump_idx_d = '0;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == S_DUMP && out_free) begin
			// Emit the front cell and move it behind the back element
			ctl.op       = OP_ROTATE;
			ctl.ins      = cell_data[0];
			target       = count_q - CNT_W'(1);
			load         = 1'b1;
			load_element = cell_data[0];
			load_last    = dump_last;
			dump_idx_d   = dump_idx_q + IDX_W'(1);
			if (dump_last) begin
				state_d = S_IDLE;
			end
		end

		if (load) begin
			rsp_valid_d = 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_d = 1'b0;
		end else begin
			rsp_valid_d = rsp_valid_q;
		end
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			dump_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			dump_idx_q  <= dump_idx_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_status_q  <= load_status;
			rsp_element_q <= load_element;
			rsp_last_q    <= load_last;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = rsp_status_q;
	assign rsp.element = rsp_element_q;
	assign rsp.last    = rsp_last_q;

	// Row of cells, cell 0 at the front
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_w;
		logic signed [DATA_W-1:0] right_w;

		assign hit[i] = (target == CNT_W'(i));

		if (i == 0) begin : g_head
			assign left_w = ctl.ins;
		end else begin : g_body
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_w = cell_data[i];
		end else begin : g_inner
			assign right_w = cell_data[i+1];
		end

		deq_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.hit   (hit[i]),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i])
		);
	end
endmodule

>>> rtl/core/deq_checker.sv
`include "double_ended_queue_defines.svh"

module deq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [1:0]                        rsp_status,
	input logic signed [deq_pkg::DATA_W-1:0] rsp_element,
	input logic                              rsp_last
);
	import deq_pkg::*;

	// A stalled result keeps its contents
	`DEQ_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element) && $stable(rsp_last), "rsp changed while stalled")

	// Only a dump gives more than one result, and those are all ok
	`DEQ_ASSERT(a_mid_ok, clk, arst_n, rsp_valid && !rsp_last |-> rsp_status == STAT_OK, "non-last result with error status")

	// An error result stands alone and carries no element
	`DEQ_ASSERT(a_err_alone, clk, arst_n, rsp_valid && rsp_status != STAT_OK |-> rsp_last && rsp_element == '0, "error result malformed")

	// No new command while a dump is still being delivered
	`DEQ_ASSERT(a_dump_block, clk, arst_n, rsp_valid && rsp_ready && !rsp_last |-> !req_ready, "command taken during dump")

	// Reset drops any pending result
	`DEQ_ASSERT_ALWAYS(a_rst_clear, clk, !arst_n |-> !rsp_valid, "rsp valid during reset")
endmodule

bind double_ended_queue deq_checker u_deq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_element (rsp.element),
	.rsp_last    (rsp.last)
);
